/* hw/rtl/efi_pkg.sv */
// Shared constants, types and helper functions of the escape-time fractal iterator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package efi_pkg;

  // Number formats: points and seeds are Q4.28, results are Q6.28.
  localparam int FRAC_BITS = 28;
  localparam int ITER_BITS = 16;
  localparam int PT_W      = 32;
  localparam int OUT_W     = 34;
  localparam int Z_W       = 38;
  localparam int PROD_W    = 2 * PT_W;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // Escape limits: |re| or |im| above two, or squared magnitude above four.
  localparam logic signed [Z_W-1:0]    TWO_LIM = Z_W'(2) <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] MAG_LIM = PROD_W'(4) <<< (2 * FRAC_BITS);

  // Saturation bounds of the result format.
  localparam logic signed [Z_W-1:0] OUT_MAX = Z_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [Z_W-1:0] OUT_MIN = -(Z_W'(64'sd1 <<< (OUT_W - 1)));

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MAX_ITER = 2'd0;
  localparam logic [1:0] REG_JULIA    = 2'd1;
  localparam logic [1:0] REG_SEED_RE  = 2'd2;
  localparam logic [1:0] REG_SEED_IM  = 2'd3;

  typedef struct packed {
    logic [ITER_BITS-1:0]   max_iter;
    logic                   julia;
    logic signed [PT_W-1:0] seed_re;
    logic signed [PT_W-1:0] seed_im;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a new request and set up z and c
    logic mul;       // capture the three products of z
    logic update;    // form the next z from the products
    logic count;     // one more iteration completed
    logic out_load;  // move the finished result to the output register
    logic out_esc;   // escape flag to store with the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic max_zero;  // no iterations allowed
    logic escape;    // current z lies outside the radius-two circle
    logic last;      // the next completed iteration reaches the limit
  } sts_t;

  // Clamp a working value of z into the Q6.28 result range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Z_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/escape_time_fractal_iterator_unit.sv */
// Escape-time fractal iterator: Mandelbrot or Julia escape-time count per point.
// A request carries point_re_i/point_im_i (signed Q4.28) on in_valid_i, taken
// when in_stall_o is low. Each result carries iteration_count_o, escaped_o and
// the last z saturated to signed Q6.28 on out_valid_o; the receiver holds it
// with out_stall_i. Mode, iteration limit and seed sit in APB registers.
// The block works on one request at a time. Each iteration of z = z*z + c
// passes first through the three 32x32 multipliers, then through the update
// adders and the escape test. The next request can be taken in the cycle
// after the result is registered.
// A finished result waits in the output register; while it is stalled the
// block may take and work on the next request, and holds that one's result
// until the output register frees.
// Reset clears the controller and the output valid, and sets the registers to
// limit 100, Mandelbrot mode and seed zero.
`default_nettype none

module escape_time_fractal_iterator_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [efi_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [efi_pkg::DATA_W-1:0]          pwdata,
  output logic      [efi_pkg::DATA_W-1:0]          prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [efi_pkg::PT_W-1:0]     point_re_i,
  input  wire logic signed [efi_pkg::PT_W-1:0]     point_im_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic        [efi_pkg::ITER_BITS-1:0]     iteration_count_o,
  output logic                                     escaped_o,
  output logic signed [efi_pkg::OUT_W-1:0]         final_re_o,
  output logic signed [efi_pkg::OUT_W-1:0]         final_im_o
);
  import efi_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  efi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  efi_datapath u_dp (
    .clk_i             (clk_i),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .point_re_i        (point_re_i),
    .point_im_i        (point_im_i),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o),
    .final_re_o        (final_re_o),
    .final_im_o        (final_im_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/efi_regs.sv */
// Configuration register file on an APB-style port.
// Depends on efi_pkg for the register indexes and the cfg_t type.
`default_nettype none

module efi_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [efi_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [efi_pkg::DATA_W-1:0]   pwdata,
  output logic      [efi_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output efi_pkg::cfg_t                     cfg_o
);
  import efi_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Write decode: the addressed register takes the new data.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_ITER: cfg_d.max_iter = pwdata[ITER_BITS-1:0];
        REG_JULIA:    cfg_d.julia    = pwdata[0];
        REG_SEED_RE:  cfg_d.seed_re  = pwdata[PT_W-1:0];
        REG_SEED_IM:  cfg_d.seed_im  = pwdata[PT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iter <= ITER_BITS'(100);
      cfg_q.julia    <= 1'b0;
      cfg_q.seed_re  <= '0;
      cfg_q.seed_im  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      REG_MAX_ITER: prdata = DATA_W'(cfg_q.max_iter);
      REG_JULIA:    prdata = DATA_W'(cfg_q.julia);
      REG_SEED_RE:  prdata = DATA_W'(cfg_q.seed_re);
      REG_SEED_IM:  prdata = DATA_W'(cfg_q.seed_im);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/efi_ctrl.sv */
// Controller state machine: sequences load, multiply, evaluate and result hand-over.
// Depends on efi_pkg for the command and status structs.
`default_nettype none

module efi_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire efi_pkg::sts_t sts_i,
  output efi_pkg::cmd_t      cmd_o
);
  import efi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   first_q, first_d;
  logic   esc_q, esc_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          first_d    = 1'b1;
          esc_d      = 1'b0;
          state_d    = sts_i.max_zero ? ST_FINISH : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        if (first_q) begin
          // The start value is never tested; go straight to the first step.
          cmd_o.update = 1'b1;
          first_d      = 1'b0;
          state_d      = ST_MUL;
        end else if (sts_i.escape) begin
          esc_d   = 1'b1;
          state_d = ST_FINISH;
        end else if (sts_i.last) begin
          cmd_o.count = 1'b1;
          state_d     = ST_FINISH;
        end else begin
          cmd_o.count  = 1'b1;
          cmd_o.update = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_esc  = esc_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/efi_datapath.sv */
// Datapath: z and c registers, the three product multipliers, the update adders,
// the escape test, the iteration counter and the output register. Depends on efi_pkg.
`default_nettype none

module efi_datapath (
  input  wire logic                                 clk_i,
  input  wire efi_pkg::cfg_t                        cfg_i,
  input  wire efi_pkg::cmd_t                        cmd_i,
  output efi_pkg::sts_t                             sts_o,
  input  wire logic signed [efi_pkg::PT_W-1:0]      point_re_i,
  input  wire logic signed [efi_pkg::PT_W-1:0]      point_im_i,
  output logic        [efi_pkg::ITER_BITS-1:0]      iteration_count_o,
  output logic                                      escaped_o,
  output logic signed [efi_pkg::OUT_W-1:0]          final_re_o,
  output logic signed [efi_pkg::OUT_W-1:0]          final_im_o
);
  import efi_pkg::*;

  logic signed [Z_W-1:0]    z_re_q, z_im_q;
  logic signed [PT_W-1:0]   c_re_q, c_im_q;
  logic signed [PROD_W-1:0] xx_q, yy_q, xy_q;
  logic                     coarse_q;
  logic [ITER_BITS-1:0]     n_q;

  logic signed [PT_W-1:0]   op_re, op_im;
  logic signed [PROD_W-1:0] diff, re_sh, im_sh, mag2;
  logic signed [Z_W-1:0]    nre, nim;
  logic                     ncoarse;
  logic [ITER_BITS:0]       n_next;

  logic [ITER_BITS-1:0]     cnt_out_q;
  logic                     esc_out_q;
  logic signed [OUT_W-1:0]  re_out_q, im_out_q;

  // Multiplier operands: z stays within Q4.28 whenever its products are used.
  assign op_re = z_re_q[PT_W-1:0];
  assign op_im = z_im_q[PT_W-1:0];

  // Next z: rescale rounds towards minus infinity, then add c.
  assign diff  = xx_q - yy_q;
  assign re_sh = diff >>> FRAC_BITS;
  assign im_sh = xy_q >>> (FRAC_BITS - 1);
  assign nre   = re_sh[Z_W-1:0] + Z_W'(c_re_q);
  assign nim   = im_sh[Z_W-1:0] + Z_W'(c_im_q);
  assign ncoarse = (nre > TWO_LIM) || (nre < -TWO_LIM) ||
                   (nim > TWO_LIM) || (nim < -TWO_LIM);

  // Fine test on the squares of the current z.
  assign mag2   = xx_q + yy_q;
  assign n_next = {1'b0, n_q} + (ITER_BITS+1)'(1);

  assign sts_o.max_zero = (cfg_i.max_iter == '0);
  assign sts_o.escape   = coarse_q || (mag2 > MAG_LIM);
  assign sts_o.last     = (n_next == {1'b0, cfg_i.max_iter});

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cfg_i.julia) begin
        z_re_q <= Z_W'(point_re_i);
        z_im_q <= Z_W'(point_im_i);
        c_re_q <= cfg_i.seed_re;
        c_im_q <= cfg_i.seed_im;
      end else begin
        z_re_q <= Z_W'(cfg_i.seed_re);
        z_im_q <= Z_W'(cfg_i.seed_im);
        c_re_q <= point_re_i;
        c_im_q <= point_im_i;
      end
      coarse_q <= 1'b0;
      n_q      <= '0;
    end else begin
      if (cmd_i.update) begin
        z_re_q   <= nre;
        z_im_q   <= nim;
        coarse_q <= ncoarse;
      end
      if (cmd_i.count) begin
        n_q <= n_next[ITER_BITS-1:0];
      end
    end
    if (cmd_i.mul) begin
      xx_q <= op_re * op_re;
      yy_q <= op_im * op_im;
      xy_q <= op_re * op_im;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cnt_out_q <= n_q;
      esc_out_q <= cmd_i.out_esc;
      re_out_q  <= sat_out(z_re_q);
      im_out_q  <= sat_out(z_im_q);
    end
  end

  assign iteration_count_o = cnt_out_q;
  assign escaped_o         = esc_out_q;
  assign final_re_o        = re_out_q;
  assign final_im_o        = im_out_q;

endmodule

`default_nettype wire

/* hw/rtl/efi_checker.sv */
// Port-level checker for the escape-time fractal iterator, bound to the top level.
// Depends on efi_pkg for field widths.
`default_nettype none

module efi_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic        [efi_pkg::ITER_BITS-1:0] iteration_count_o,
  input wire logic                                escaped_o,
  input wire logic signed [efi_pkg::OUT_W-1:0]    final_re_o,
  input wire logic signed [efi_pkg::OUT_W-1:0]    final_im_o
);
  import efi_pkg::*;

  localparam logic signed [OUT_W-1:0] TWO_OUT = OUT_W'(2) <<< FRAC_BITS;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(iteration_count_o) && $stable(escaped_o) &&
      $stable(final_re_o) && $stable(final_im_o))
    else $error("result payload changed while stalled");

  // One request at a time: after a request is taken the input side is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  // A point that completed iterations without escaping ends inside radius two.
  a_bounded_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !escaped_o && (iteration_count_o != '0) |->
      (final_re_o <= TWO_OUT) && (final_re_o >= -TWO_OUT) &&
      (final_im_o <= TWO_OUT) && (final_im_o >= -TWO_OUT))
    else $error("non-escaped result lies outside the radius-two box");

endmodule

bind escape_time_fractal_iterator_unit efi_checker u_efi_checker (.*);

`default_nettype wire
